// ----- src/lpbf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and tables of the length-partitioned bit filter.
// No dependencies; every other file uses this package.
package lpbf_pkg;

  localparam int FILTER_BYTES_DEF = 131072;
  localparam int MIN_LEN_DEF      = 5;
  localparam int MAX_LEN_DEF      = 13;

  localparam int LEN_W    = 6;
  localparam int CH_W     = 8;
  localparam int MULT_W   = 8;
  localparam int SCALE_W  = 6;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int WEIGHT_W = 5;
  localparam int PREFIX_W = 7;
  localparam int SQ_W     = 11;
  localparam int SIZE_W   = 15;
  localparam int OFS_W    = 15;
  localparam int DVD_W    = 23;
  localparam int START_W  = 18;
  localparam int HASH_ADDR_W = 18;
  localparam int BIT_W    = 3;
  localparam int LEN_CNT  = 1 << LEN_W;

  localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(36);
  localparam logic [SCALE_W-1:0] SCALE_MIN = SCALE_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_BYTE_MULT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MULT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = CFG_IDX_W'(2);

  localparam logic [MULT_W-1:0]  BYTE_MULT_RST = MULT_W'(31);
  localparam logic [MULT_W-1:0]  BIT_MULT_RST  = MULT_W'(32);
  localparam logic [SCALE_W-1:0] SCALE_RST     = SCALE_W'(29);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [CH_W-1:0]      ch_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;

  typedef enum logic [2:0] {
    OP_FETCH,
    OP_SQUARE,
    OP_MUL,
    OP_DIV,
    OP_ADDR,
    OP_READ,
    OP_WAIT,
    OP_RESP
  } op_e;

  typedef struct packed {
    logic req;
    logic bad_len;
    logic div_busy;
    logic not_last;
    logic out_busy;
  } seq_status_t;

  typedef logic [PREFIX_W-1:0] prefix_tab_t [LEN_CNT];

  function automatic logic [WEIGHT_W-1:0] weight_of(len_t len);
    logic [WEIGHT_W-1:0] w;
    case (len)
      LEN_W'(5):  w = WEIGHT_W'(5);
      LEN_W'(6):  w = WEIGHT_W'(9);
      LEN_W'(7):  w = WEIGHT_W'(13);
      LEN_W'(8):  w = WEIGHT_W'(15);
      LEN_W'(9):  w = WEIGHT_W'(16);
      LEN_W'(10): w = WEIGHT_W'(15);
      LEN_W'(11): w = WEIGHT_W'(12);
      LEN_W'(12): w = WEIGHT_W'(9);
      LEN_W'(13): w = WEIGHT_W'(6);
      default:    w = '0;
    endcase
    return w;
  endfunction

  // Sum of the weights of all shorter lengths from min_len up.
  function automatic prefix_tab_t prefix_table(int min_len);
    prefix_tab_t tab;
    int sum;
    sum = 0;
    for (int l = 0; l < LEN_CNT; l++) begin
      tab[l] = PREFIX_W'(sum);
      if (l >= min_len) sum += int'(weight_of(LEN_W'(l)));
    end
    return tab;
  endfunction

endpackage

// ----- src/lpbf_if.sv -----
`timescale 1ns / 1ps
// Request and response channel interfaces of the bit filter.
// Depends on lpbf_pkg for payload types.
interface lpbf_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  lpbf_pkg::len_t    word_len;
  lpbf_pkg::ch_t     ch;
  logic              last;

  modport source (output valid, kind, word_len, ch, last, input ready);
  modport sink   (input valid, kind, word_len, ch, last, output ready);
endinterface

interface lpbf_out_if;
  logic valid;
  logic ready;
  logic present;

  modport source (output valid, present, input ready);
  modport sink   (input valid, present, output ready);
endinterface

// ----- src/lpbf_seq.sv -----
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on lpbf_pkg for the op codes and the status struct.
module lpbf_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lpbf_pkg::seq_status_t status_i,
  output lpbf_pkg::op_e         op_o
);
  import lpbf_pkg::*;

  localparam int STEP_W = 3;

  localparam logic [STEP_W-1:0] S_FETCH  = STEP_W'(0);
  localparam logic [STEP_W-1:0] S_SQUARE = STEP_W'(1);
  localparam logic [STEP_W-1:0] S_MUL    = STEP_W'(2);
  localparam logic [STEP_W-1:0] S_DIV    = STEP_W'(3);
  localparam logic [STEP_W-1:0] S_ADDR   = STEP_W'(4);
  localparam logic [STEP_W-1:0] S_READ   = STEP_W'(5);
  localparam logic [STEP_W-1:0] S_WAIT   = STEP_W'(6);
  localparam logic [STEP_W-1:0] S_RESP   = STEP_W'(7);

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_BAD_LEN,
    C_DIV_BUSY,
    C_NOT_LAST,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      S_FETCH:  w = '{op: OP_FETCH,  cond: C_NO_REQ,   target: S_FETCH};
      S_SQUARE: w = '{op: OP_SQUARE, cond: C_BAD_LEN,  target: S_READ};
      S_MUL:    w = '{op: OP_MUL,    cond: C_NEVER,    target: S_FETCH};
      S_DIV:    w = '{op: OP_DIV,    cond: C_DIV_BUSY, target: S_DIV};
      S_ADDR:   w = '{op: OP_ADDR,   cond: C_NEVER,    target: S_FETCH};
      S_READ:   w = '{op: OP_READ,   cond: C_NOT_LAST, target: S_FETCH};
      S_WAIT:   w = '{op: OP_WAIT,   cond: C_OUT_BUSY, target: S_WAIT};
      S_RESP:   w = '{op: OP_RESP,   cond: C_ALWAYS,   target: S_FETCH};
      default:  w = '{op: OP_FETCH,  cond: C_NO_REQ,   target: S_FETCH};
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] step_q, step_d;
  uword_t            uw;
  logic              jump;

  always_comb begin
    uw = ucode(step_q);
    case (uw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_REQ:   jump = !status_i.req;
      C_BAD_LEN:  jump = status_i.bad_len;
      C_DIV_BUSY: jump = status_i.div_busy;
      C_NOT_LAST: jump = status_i.not_last;
      C_OUT_BUSY: jump = status_i.out_busy;
      default:    jump = 1'b0;
    endcase
    step_d = jump ? uw.target : step_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  assign op_o = uw.op;

endmodule

// ----- src/length_partitioned_bit_filter_top.sv -----
`timescale 1ns / 1ps
// Length-partitioned bit filter: top level with datapath and bit table.
// Depends on lpbf_pkg, lpbf_if and lpbf_seq.
//
// One character is taken per request. For a character of a word whose length
// has a region, the offset hash is reduced by a restoring modulo step, one
// dividend bit per cycle over 23 bits, in the sequencer's loop; the last
// character of the word adds a read-modify-write of the bit table. After
// reset the table is zeroed one byte per cycle, during which no request is
// taken; configuration writes are taken throughout. A query response sits
// in an output register, so the next request is taken while it waits.
module length_partitioned_bit_filter_top #(
  parameter int FilterBytes = lpbf_pkg::FILTER_BYTES_DEF,
  parameter int MinLen      = lpbf_pkg::MIN_LEN_DEF,
  parameter int MaxLen      = lpbf_pkg::MAX_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  lpbf_pkg::cfg_idx_t   cfg_idx_i,
  input  lpbf_pkg::cfg_data_t  cfg_data_i,
  lpbf_in_if.sink              in_req_i,
  lpbf_out_if.source           out_rsp_o
);
  import lpbf_pkg::*;

  localparam int AddrW = $clog2(FilterBytes);
  localparam int FullW = (AddrW > HASH_ADDR_W) ? AddrW : HASH_ADDR_W;
  localparam prefix_tab_t PrefixTab = prefix_table(MinLen);

  logic [MULT_W-1:0]  byte_mult_q, bit_mult_q;
  logic [SCALE_W-1:0] scale_q;

  logic               kind_q, last_q, ok_q;
  len_t               len_q;
  ch_t                ch_q;
  logic [SQ_W-1:0]    sq_q;
  logic [SIZE_W-1:0]  size_q;
  logic [START_W-1:0] start_q;
  logic [DVD_W-1:0]   dvd_q;
  logic [OFS_W-1:0]   rem_q;
  logic [4:0]         cnt_q;
  logic [FullW-1:0]   addr_q;
  logic               in_table_q;
  logic [OFS_W-1:0]   oh_q, oh_d;
  logic [BIT_W-1:0]   bh_q, bh_d;
  logic               out_valid_q, out_valid_d;
  logic               present_q;
  logic               clr_busy_q;
  logic [AddrW-1:0]   clr_addr_q;
  logic [7:0]         rdata_q;

  logic [7:0]         mem [FilterBytes];

  op_e                op;
  seq_status_t        status;
  logic               accept;
  logic               ok_in;
  logic [SCALE_W-1:0] scale_sat;
  logic [2*SCALE_W-1:0] sq_full;
  logic [OFS_W:0]     trial;
  logic [OFS_W:0]     trial_sub;
  logic               mem_we;
  logic [AddrW-1:0]   mem_wa;
  logic [7:0]         mem_wd;
  logic               do_insert;

  lpbf_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  assign in_req_i.ready = (op == OP_FETCH) && !clr_busy_q;
  assign accept = in_req_i.valid && in_req_i.ready;

  assign ok_in = (int'(in_req_i.word_len) >= MinLen) && (int'(in_req_i.word_len) <= MaxLen)
                 && (weight_of(in_req_i.word_len) != '0);

  assign status.req      = accept;
  assign status.bad_len  = !ok_q;
  assign status.div_busy = (cnt_q != 5'(DVD_W - 1));
  assign status.not_last = !last_q;
  assign status.out_busy = (kind_q == KIND_QUERY) && out_valid_q && !out_rsp_o.ready;

  assign scale_sat = (scale_q < SCALE_MIN) ? SCALE_MIN :
                     (scale_q > SCALE_MAX) ? SCALE_MAX : scale_q;
  assign sq_full   = (2*SCALE_W)'(scale_sat) * (2*SCALE_W)'(scale_sat);

  assign trial     = {rem_q, dvd_q[DVD_W-1]};
  assign trial_sub = trial - {1'b0, size_q};

  assign do_insert = (op == OP_RESP) && (kind_q == KIND_INSERT) && in_table_q;
  assign mem_we    = clr_busy_q || do_insert;
  assign mem_wa    = clr_busy_q ? clr_addr_q : addr_q[AddrW-1:0];
  assign mem_wd    = clr_busy_q ? 8'h00 : (rdata_q | (8'h01 << bh_q));

  always_comb begin
    oh_d        = oh_q;
    bh_d        = bh_q;
    out_valid_d = out_valid_q && !out_rsp_o.ready;
    case (op)
      OP_MUL:  bh_d = bit_mult_q[BIT_W-1:0] * bh_q + ch_q[BIT_W-1:0];
      OP_ADDR: oh_d = rem_q;
      OP_RESP: begin
        oh_d = '0;
        bh_d = '0;
        if (kind_q == KIND_QUERY) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_mult_q <= BYTE_MULT_RST;
      bit_mult_q  <= BIT_MULT_RST;
      scale_q     <= SCALE_RST;
      oh_q        <= '0;
      bh_q        <= '0;
      out_valid_q <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BYTE_MULT: byte_mult_q <= cfg_data_i[MULT_W-1:0];
          REG_BIT_MULT:  bit_mult_q  <= cfg_data_i[MULT_W-1:0];
          REG_SCALE:     scale_q     <= cfg_data_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      oh_q        <= oh_d;
      bh_q        <= bh_d;
      out_valid_q <= out_valid_d;
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
        if (clr_addr_q == AddrW'(FilterBytes - 1)) clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op)
      OP_FETCH: begin
        if (accept) begin
          kind_q <= in_req_i.kind;
          len_q  <= in_req_i.word_len;
          ch_q   <= in_req_i.ch;
          last_q <= in_req_i.last;
          ok_q   <= ok_in;
        end
      end
      OP_SQUARE: sq_q <= sq_full[SQ_W-1:0];
      OP_MUL: begin
        size_q  <= SIZE_W'(weight_of(len_q)) * SIZE_W'(sq_q);
        start_q <= START_W'(PrefixTab[len_q]) * START_W'(sq_q);
        dvd_q   <= DVD_W'(byte_mult_q) * DVD_W'(oh_q) + DVD_W'(ch_q);
        rem_q   <= '0;
        cnt_q   <= '0;
      end
      OP_DIV: begin
        rem_q <= (trial >= {1'b0, size_q}) ? trial_sub[OFS_W-1:0] : trial[OFS_W-1:0];
        dvd_q <= dvd_q << 1;
        cnt_q <= cnt_q + 5'd1;
      end
      OP_ADDR: addr_q <= FullW'(start_q) + FullW'(rem_q);
      OP_READ: in_table_q <= ok_q && (32'(addr_q) < 32'(FilterBytes));
      OP_RESP: begin
        if (kind_q == KIND_QUERY) present_q <= in_table_q && rdata_q[bh_q];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (op == OP_READ) rdata_q <= mem[addr_q[AddrW-1:0]];
  end

  assign out_rsp_o.valid   = out_valid_q;
  assign out_rsp_o.present = present_q;

  a_accept_to_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (op == OP_SQUARE))
    else $error("request not followed by the square step");

  a_clear_blocks_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_req_i.ready)
    else $error("request taken during table clear");

  a_rem_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_ADDR) |-> (rem_q < size_q))
    else $error("offset hash not below region size");

  a_resp_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((op == OP_RESP) && (kind_q == KIND_QUERY)) |-> !out_valid_q)
    else $error("response loaded over a pending response");

endmodule
